>>> design/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // Field and accumulator widths
  localparam int RawW   = 24;
  localparam int PressW = 29;
  localparam int SumW   = 33;
  localparam int CntW   = 4;
  localparam int ErrW   = 8;
  localparam int StatW  = 2;

  // Divider: one quotient bit per cycle over the whole sum magnitude
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  // Calibration length and conversion constants
  localparam logic [CntW-1:0]          CalSamples    = CntW'(10);
  localparam logic signed [PressW-1:0] PressOffset   = PressW'(62914560);
  localparam logic [ErrW-1:0]          ErrMax        = {ErrW{1'b1}};
  localparam logic [ErrW-1:0]          ErrLimitReset = ErrW'(5);

  // Result status codes
  localparam logic [StatW-1:0] STAT_FRESH   = 2'd0;
  localparam logic [StatW-1:0] STAT_HELD    = 2'd1;
  localparam logic [StatW-1:0] STAT_INVALID = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic            req_type;
    logic            trigger_ok;
    logic            read_ok;
    logic [7:0]      byte_high;
    logic [7:0]      byte_mid;
    logic [7:0]      byte_low;
  } in_item_t;

  typedef struct packed {
    logic signed [PressW-1:0] pressure;
    logic [StatW-1:0]         status;
    logic                     sensor_valid;
    logic                     cal_done;
    logic                     cal_failed;
    logic [CntW-1:0]          cal_valid_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_last;
    logic slot_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

>>> design/psc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psc_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       trigger_ok;
  logic       read_ok;
  logic [7:0] byte_high;
  logic [7:0] byte_mid;
  logic [7:0] byte_low;

  modport source (output valid, output req_type, output trigger_ok, output read_ok,
                  output byte_high, output byte_mid, output byte_low, input ready);
  modport sink (input valid, input req_type, input trigger_ok, input read_ok,
                input byte_high, input byte_mid, input byte_low, output ready);
endinterface

`default_nettype wire

>>> design/psc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [psc_pkg::PressW-1:0] pressure;
  logic [psc_pkg::StatW-1:0]        status;
  logic                             sensor_valid;
  logic                             cal_done;
  logic                             cal_failed;
  logic [psc_pkg::CntW-1:0]         cal_valid_count;

  modport source (output valid, output pressure, output status, output sensor_valid,
                  output cal_done, output cal_failed, output cal_valid_count, input ready);
  modport sink (input valid, input pressure, input status, input sensor_valid,
                input cal_done, input cal_failed, input cal_valid_count, output ready);
endinterface

`default_nettype wire

>>> design/psc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire psc_pkg::ctl_sts_t sts,
  output psc_pkg::ctl_cmd_t      cmd
);

  psc_pkg::state_t state, state_next;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      psc_pkg::ST_IDLE: begin
        if (in_valid) state_next = psc_pkg::ST_EVAL;
      end
      psc_pkg::ST_EVAL: begin
        state_next = sts.div_need ? psc_pkg::ST_DIV : psc_pkg::ST_PUSH;
      end
      psc_pkg::ST_DIV: begin
        if (sts.div_last) state_next = psc_pkg::ST_PUSH;
      end
      psc_pkg::ST_PUSH: begin
        if (sts.slot_free) state_next = psc_pkg::ST_IDLE;
      end
      default: state_next = psc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      psc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      psc_pkg::ST_EVAL: cmd.eval     = 1'b1;
      psc_pkg::ST_DIV:  cmd.div_step = 1'b1;
      psc_pkg::ST_PUSH: cmd.push     = sts.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/psc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [psc_pkg::ErrW-1:0]  cfg_wdata,
  input  wire psc_pkg::in_item_t         in_item,
  input  wire psc_pkg::ctl_cmd_t         cmd,
  output psc_pkg::ctl_sts_t              sts,
  output psc_pkg::out_item_t             out_item,
  output logic                           out_valid,
  input  wire logic                      out_ready
);

  localparam int PressW = psc_pkg::PressW;
  localparam int SumW   = psc_pkg::SumW;
  localparam int CntW   = psc_pkg::CntW;
  localparam int ErrW   = psc_pkg::ErrW;
  localparam int RawW   = psc_pkg::RawW;

  // Configuration and persistent state
  logic [ErrW-1:0]          error_limit;
  logic signed [PressW-1:0] zero_offset;
  logic signed [PressW-1:0] last_good;
  logic [ErrW-1:0]          err_count;
  logic signed [SumW-1:0]   cal_sum;
  logic [CntW-1:0]          cal_valid;
  logic [CntW-1:0]          cal_attempts;

  // Item and result holding
  psc_pkg::in_item_t        in_q;
  psc_pkg::out_item_t       res_q;
  psc_pkg::out_item_t       res_next;

  // Divider registers
  logic [SumW-1:0]                div_quo;
  logic [CntW-1:0]                div_rem;
  logic [CntW-1:0]                div_den;
  logic                           div_neg;
  logic [psc_pkg::DivCntW-1:0]    div_cnt;

  // Evaluation signals
  logic [RawW-1:0]          raw;
  logic signed [PressW-1:0] raw_ext;
  logic signed [PressW-1:0] p_abs;
  logic signed [PressW-1:0] p_corr;
  logic                     ok;
  logic                     is_cal;
  logic [ErrW-1:0]          err_inc;
  logic [ErrW-1:0]          err_new;
  logic signed [SumW-1:0]   sum_new;
  logic [SumW-1:0]          sum_mag;
  logic [CntW-1:0]          valid_new;
  logic [CntW-1:0]          att_new;
  logic                     cal_end;
  logic                     div_need;

  // Divider step signals
  logic [CntW:0]            rem_sh;
  logic [CntW:0]            rem_diff;
  logic                     rem_ge;
  logic [CntW-1:0]          rem_nx;
  logic [SumW-1:0]          quo_nx;
  logic [SumW-1:0]          quo_signed;

  // Convert the code: 15*raw is 16*raw - raw
  always_comb begin
    raw     = {in_q.byte_high, in_q.byte_mid, in_q.byte_low};
    raw_ext = {{(PressW-RawW){raw[RawW-1]}}, raw};
    p_abs   = {raw_ext[PressW-5:0], 4'b0000} - raw_ext - psc_pkg::PressOffset;
    p_corr  = p_abs - zero_offset;
  end

  // Work out state updates and the result for the held item
  always_comb begin
    is_cal    = in_q.req_type;
    ok        = in_q.trigger_ok & in_q.read_ok;
    err_inc   = (err_count == psc_pkg::ErrMax) ? err_count : err_count + ErrW'(1);
    err_new   = is_cal ? err_count : (ok ? '0 : err_inc);
    sum_new   = ok ? cal_sum + {{(SumW-PressW){p_abs[PressW-1]}}, p_abs} : cal_sum;
    sum_mag   = sum_new[SumW-1] ? (~sum_new + SumW'(1)) : sum_new;
    valid_new = ok ? cal_valid + CntW'(1) : cal_valid;
    att_new   = cal_attempts + CntW'(1);
    cal_end   = is_cal && (att_new >= psc_pkg::CalSamples);
    div_need  = cal_end && (valid_new != '0);

    res_next                 = '0;
    res_next.status          = psc_pkg::STAT_FRESH;
    res_next.sensor_valid    = err_new < error_limit;
    res_next.cal_done        = div_need;
    res_next.cal_failed      = cal_end && (valid_new == '0);
    res_next.cal_valid_count = is_cal ? valid_new : cal_valid;
    if (!is_cal) begin
      if (ok) begin
        res_next.pressure = p_corr;
      end else if (err_inc >= error_limit) begin
        res_next.status   = psc_pkg::STAT_INVALID;
      end else begin
        res_next.status   = psc_pkg::STAT_HELD;
        res_next.pressure = last_good;
      end
    end
  end

  // One restoring divide step on the sum magnitude
  always_comb begin
    rem_sh     = {div_rem, div_quo[SumW-1]};
    rem_ge     = rem_sh >= {1'b0, div_den};
    rem_diff   = rem_sh - {1'b0, div_den};
    rem_nx     = rem_ge ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
    quo_nx     = {div_quo[SumW-2:0], rem_ge};
    quo_signed = div_neg ? (~quo_nx + SumW'(1)) : quo_nx;
  end

  // Status to the controller
  always_comb begin
    sts.div_need  = div_need;
    sts.div_last  = div_cnt == psc_pkg::DivLast;
    sts.slot_free = !out_valid || out_ready;
  end

  // Hold configuration, tracking state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit  <= psc_pkg::ErrLimitReset;
      zero_offset  <= '0;
      last_good    <= '0;
      err_count    <= '0;
      cal_sum      <= '0;
      cal_valid    <= '0;
      cal_attempts <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) error_limit <= cfg_wdata;
      if (cmd.eval) begin
        err_count <= err_new;
        if (!is_cal && ok) last_good <= p_corr;
        if (is_cal) begin
          if (cal_end) begin
            cal_sum      <= '0;
            cal_valid    <= '0;
            cal_attempts <= '0;
          end else begin
            cal_sum      <= sum_new;
            cal_valid    <= valid_new;
            cal_attempts <= att_new;
          end
        end
      end
      if (cmd.div_step && sts.div_last) zero_offset <= quo_signed[PressW-1:0];
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture payload: input item, result, divider and output register
  always_ff @(posedge clk) begin
    if (cmd.load) in_q <= in_item;
    if (cmd.eval) begin
      res_q   <= res_next;
      div_quo <= sum_mag;
      div_rem <= '0;
      div_den <= valid_new;
      div_neg <= sum_new[SumW-1];
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_quo <= quo_nx;
      div_rem <= rem_nx;
      div_cnt <= div_cnt + psc_pkg::DivCntW'(1);
    end
    if (cmd.push) out_item <= res_q;
  end

endmodule

`default_nettype wire

>>> design/pressure_sample_conditioner_core.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    req_type, trigger_ok, read_ok, byte_high, byte_mid, byte_low
// out_ch    out  valid/ready    pressure, status, sensor_valid, cal_done, cal_failed,
//                               cal_valid_count
// cfg       in   cfg_we         cfg_wdata -> error_limit
//
// A transaction is accepted in the idle state; its result is registered in the evaluate state
// and moves to the output register in the push state; the next transaction is taken once the
// block is back in the idle state.
// A calibration transaction that closes a run with valid samples also passes through the
// one-bit-per-cycle divider that computes the new zero offset before the push state.
// Reset (rst, synchronous) sets error_limit to 5 and clears offset, counters and sums.
// A stalled output holds the result; one more transaction may be processed meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module pressure_sample_conditioner_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [psc_pkg::ErrW-1:0] cfg_wdata,
  psc_in_if.sink                        in_ch,
  psc_out_if.source                     out_ch
);

  psc_pkg::in_item_t  in_item;
  psc_pkg::out_item_t out_item;
  psc_pkg::ctl_cmd_t  cmd;
  psc_pkg::ctl_sts_t  sts;
  logic               in_ready;
  logic               out_valid;

  // Pack the input transaction
  always_comb begin
    in_item.req_type   = in_ch.req_type;
    in_item.trigger_ok = in_ch.trigger_ok;
    in_item.read_ok    = in_ch.read_ok;
    in_item.byte_high  = in_ch.byte_high;
    in_item.byte_mid   = in_ch.byte_mid;
    in_item.byte_low   = in_ch.byte_low;
  end

  assign in_ch.ready = in_ready;

  // Unpack the output transaction
  assign out_ch.valid           = out_valid;
  assign out_ch.pressure        = out_item.pressure;
  assign out_ch.status          = out_item.status;
  assign out_ch.sensor_valid    = out_item.sensor_valid;
  assign out_ch.cal_done        = out_item.cal_done;
  assign out_ch.cal_failed      = out_item.cal_failed;
  assign out_ch.cal_valid_count = out_item.cal_valid_count;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire

>>> verif/psc_checker.sv
`timescale 1ns / 1ps

module psc_checker
  import psc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ErrW-1:0]   cfg_wdata,
  psc_in_if                 in_ch,
  psc_out_if                out_ch,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  // Predicted block state
  logic [ErrW-1:0] err_limit;
  logic [ErrW-1:0] fail_run;
  int              zero_offset;
  int              last_good;
  longint          cal_acc;
  logic [CntW-1:0] cal_hits;
  logic [CntW-1:0] cal_tries;

  out_item_t expected_readings[$];
  out_item_t got;
  out_item_t want;
  in_item_t  taken;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    $display("%0t: %s got %0d, expected %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // Advance the predicted state by one measurement attempt and return its result
  function automatic out_item_t condition_sample(input in_item_t it);
    logic signed [RawW-1:0] raw;
    int                     p_abs;
    int                     p_out;
    logic                   good;
    out_item_t              r;
    raw   = {it.byte_high, it.byte_mid, it.byte_low};
    p_abs = 15 * int'(raw) - int'(PressOffset);
    good  = it.trigger_ok && it.read_ok;
    r     = '0;
    if (!it.req_type) begin
      // normal reading: fresh, held or invalid
      if (good) begin
        fail_run   = '0;
        p_out      = p_abs - zero_offset;
        last_good  = p_out;
        r.status   = STAT_FRESH;
        r.pressure = PressW'(p_out);
      end else begin
        if (fail_run != ErrMax) begin
          fail_run = fail_run + 1'b1;
        end
        if (fail_run >= err_limit) begin
          r.status = STAT_INVALID;
        end else begin
          r.status   = STAT_HELD;
          r.pressure = PressW'(last_good);
        end
      end
      r.cal_valid_count = cal_hits;
    end else begin
      // calibration sample: accumulate, close the run after CalSamples attempts
      if (good) begin
        cal_acc  = cal_acc + longint'(p_abs);
        cal_hits = cal_hits + 1'b1;
      end
      cal_tries         = cal_tries + 1'b1;
      r.cal_valid_count = cal_hits;
      if (cal_tries >= CalSamples) begin
        if (cal_hits != '0) begin
          zero_offset = int'(cal_acc / longint'(cal_hits));
          r.cal_done  = 1'b1;
        end else begin
          r.cal_failed = 1'b1;
        end
        cal_acc   = 0;
        cal_hits  = '0;
        cal_tries = '0;
      end
    end
    r.sensor_valid = (fail_run < err_limit);
    return r;
  endfunction

  // Track config, compare results, predict accepted transactions
  always @(posedge clk) begin
    if (rst) begin
      err_limit   = ErrLimitReset;
      fail_run    = '0;
      zero_offset = 0;
      last_good   = 0;
      cal_acc     = 0;
      cal_hits    = '0;
      cal_tries   = '0;
      fail_count  = 0;
      expected_readings.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        err_limit = cfg_wdata;
      end

      if (out_ch.valid && out_ch.ready) begin
        got.pressure        = out_ch.pressure;
        got.status          = out_ch.status;
        got.sensor_valid    = out_ch.sensor_valid;
        got.cal_done        = out_ch.cal_done;
        got.cal_failed      = out_ch.cal_failed;
        got.cal_valid_count = out_ch.cal_valid_count;
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result, pressure", longint'(got.pressure), 0);
        end else begin
          want = expected_readings.pop_front();
          if (got.pressure !== want.pressure) begin
            report_mismatch("pressure", longint'(got.pressure), longint'(want.pressure));
          end
          if (got.status !== want.status) begin
            report_mismatch("status", got.status, want.status);
          end
          if (got.sensor_valid !== want.sensor_valid) begin
            report_mismatch("sensor_valid", got.sensor_valid, want.sensor_valid);
          end
          if (got.cal_done !== want.cal_done) begin
            report_mismatch("cal_done", got.cal_done, want.cal_done);
          end
          if (got.cal_failed !== want.cal_failed) begin
            report_mismatch("cal_failed", got.cal_failed, want.cal_failed);
          end
          if (got.cal_valid_count !== want.cal_valid_count) begin
            report_mismatch("cal_valid_count", got.cal_valid_count, want.cal_valid_count);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        taken.req_type   = in_ch.req_type;
        taken.trigger_ok = in_ch.trigger_ok;
        taken.read_ok    = in_ch.read_ok;
        taken.byte_high  = in_ch.byte_high;
        taken.byte_mid   = in_ch.byte_mid;
        taken.byte_low   = in_ch.byte_low;
        expected_readings.push_back(condition_sample(taken));
      end

      pending <= expected_readings.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import psc_pkg::*;

  // Request kinds on the input channel
  localparam logic REQ_NORMAL = 1'b0;
  localparam logic REQ_CAL    = 1'b1;

  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ModeLength  = 64;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [ErrW-1:0] cfg_wdata;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  int unsigned mismatches;
  int unsigned readings_pending;

  int unsigned items_sent;
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned quiet_cycles;
  logic [ErrW-1:0] cur_limit;
  bit          hold_out;

  pressure_sample_conditioner_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  psc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (mismatches),
    .pending    (readings_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t sample(input logic req, input logic trig, input logic rd,
                                      input logic [RawW-1:0] code);
    in_item_t it;
    it.req_type   = req;
    it.trigger_ok = trig;
    it.read_ok    = rd;
    {it.byte_high, it.byte_mid, it.byte_low} = code;
    return it;
  endfunction

  // Mostly random codes, with the range ends now and then
  function automatic logic [RawW-1:0] pick_code();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return 24'h000000;
        1:       return 24'h7FFFFF;
        2:       return 24'h800000;
        default: return 24'hFFFFFF;
      endcase
    end
    return RawW'($urandom());
  endfunction

  // Attempt where trigger or read (or both) failed
  function automatic in_item_t failed_attempt(input logic req);
    logic [1:0] flags;
    flags = 2'($urandom_range(2));
    return sample(req, flags[1], flags[0], pick_code());
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_sample(input in_item_t it);
    int unsigned gap;
    if (items_sent % ModeLength == 0) begin
      in_gap_max    = ($urandom_range(2) == 0) ? 0 : 10;
      out_stall_max = ($urandom_range(2) == 0) ? 0 : 10;
    end
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= it.req_type;
    in_ch.trigger_ok <= it.trigger_ok;
    in_ch.read_ok    <= it.read_ok;
    in_ch.byte_high  <= it.byte_high;
    in_ch.byte_mid   <= it.byte_mid;
    in_ch.byte_low   <= it.byte_low;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (readings_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_error_limit(input logic [ErrW-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = value;
  endtask

  // Good readings followed by a failure streak around the limit
  task automatic reading_burst();
    int unsigned n_good;
    int unsigned n_bad;
    int unsigned cap;
    n_good = $urandom_range(8, 1);
    cap    = (cur_limit + 2 > 12) ? 12 : cur_limit + 2;
    n_bad  = $urandom_range(cap, 0);
    repeat (n_good) send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, pick_code()));
    repeat (n_bad) send_sample(failed_attempt(REQ_NORMAL));
  endtask

  // One full calibration run, optionally with normal readings mixed in
  task automatic calibration_run();
    int unsigned      ok_pct;
    bit               mix;
    bit               fixed;
    logic [RawW-1:0]  fixed_code;
    case ($urandom_range(3))
      0:       ok_pct = 0;
      1:       ok_pct = 40;
      2:       ok_pct = 90;
      default: ok_pct = 100;
    endcase
    mix        = 1'($urandom_range(1));
    fixed      = ($urandom_range(5) == 0);
    fixed_code = ($urandom_range(1) == 0) ? 24'h800000 : 24'h7FFFFF;
    repeat (CalSamples) begin
      if (mix && $urandom_range(3) == 0) begin
        if ($urandom_range(3) == 0) begin
          send_sample(failed_attempt(REQ_NORMAL));
        end else begin
          send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, pick_code()));
        end
      end
      if ($urandom_range(99) < ok_pct) begin
        send_sample(sample(REQ_CAL, 1'b1, 1'b1, fixed ? fixed_code : pick_code()));
      end else begin
        send_sample(failed_attempt(REQ_CAL));
      end
    end
  endtask

  // Fully random transactions, including stray calibration samples
  task automatic random_noise();
    repeat ($urandom_range(4, 1)) begin
      send_sample(sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), RawW'($urandom())));
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        reading_burst();
      end else if (pick < 80) begin
        calibration_run();
      end else begin
        random_noise();
      end
    end
  endtask

  // Range ends, every failure kind, a mixed calibration run, then a run to invalid
  task automatic directed_checks();
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h000000));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h7FFFFF));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h800000));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'hFFFFFF));
    send_sample(sample(REQ_NORMAL, 1'b0, 1'b1, 24'h5A5A5A));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b0, 24'hA5A5A5));
    send_sample(sample(REQ_NORMAL, 1'b0, 1'b0, 24'hFFFFFF));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h123456));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h800000));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'hFFFFFF));
    send_sample(sample(REQ_CAL,    1'b0, 1'b1, 24'h7FFFFF));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h000001));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h7FFFFF));
    send_sample(sample(REQ_CAL,    1'b1, 1'b0, 24'h000000));
    send_sample(sample(REQ_NORMAL, 1'b0, 1'b0, 24'h000000));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h400000));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h000000));
    send_sample(sample(REQ_CAL,    1'b0, 1'b0, 24'h800000));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h800000));
    send_sample(sample(REQ_CAL,    1'b1, 1'b1, 24'h7FFFFF));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, 24'h000000));
    repeat (5) send_sample(failed_attempt(REQ_NORMAL));
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = $urandom_range(out_stall_max, 0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    items_sent    = 0;
    in_gap_max    = 10;
    out_stall_max = 10;
    cur_limit     = ErrLimitReset;
    hold_out      = 1'b0;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_NORMAL;
    in_ch.trigger_ok <= 1'b0;
    in_ch.read_ok    <= 1'b0;
    in_ch.byte_high  <= '0;
    in_ch.byte_mid   <= '0;
    in_ch.byte_low   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();
    run_phase(250);
    drain();

    write_error_limit(8'd1);
    run_phase(250);
    drain();

    write_error_limit(8'd0);
    run_phase(150);
    drain();

    // Saturate the failure count, then stall the output while input keeps coming
    write_error_limit(8'd255);
    repeat (260) send_sample(failed_attempt(REQ_NORMAL));
    send_sample(sample(REQ_NORMAL, 1'b1, 1'b1, pick_code()));
    hold_out = 1'b1;
    run_phase(250);
    drain();

    write_error_limit(ErrW'($urandom_range(20, 2)));
    run_phase(250);
    drain();

    write_error_limit(8'd3);
    run_phase(250);
    drain();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
